// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the tpad rtl, clocked on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define TPAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TPAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tpad_pkg.sv =====
// ----------------------------------------------------------------------------
// tpad_pkg
// shared types and constants of the track pulse timer and analog detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpad_pkg;

  localparam int unsigned CFG_W    = 8;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [CFG_W-1:0] DETECT_COUNT_RST = 8'd8;
  localparam logic [CFG_W-1:0] VOTE_WINDOW_RST  = 8'h1F;
  localparam logic [CFG_W-1:0] FWD_MARGIN_RST   = 8'd13;
  localparam logic [CFG_W-1:0] BWD_MARGIN_RST   = 8'd9;

  localparam logic [CFG_W-1:0] BYTE_FULL = 8'hFF;
  localparam logic [CFG_W-1:0] BYTE_PRE_FULL = 8'hFE;

  typedef enum logic [1:0] {
    REG_DETECT_COUNT = 2'd0,
    REG_VOTE_WINDOW  = 2'd1,
    REG_FWD_MARGIN   = 2'd2,
    REG_BWD_MARGIN   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE     = 2'd0,
    DIR_BACKWARD = 2'd1,
    DIR_FORWARD  = 2'd2
  } dir_e;

  typedef struct packed {
    logic [CFG_W-1:0] detect_count;
    logic [CFG_W-1:0] vote_window;
    logic [CFG_W-1:0] fwd_margin;
    logic [CFG_W-1:0] bwd_margin;
  } cfg_t;

endpackage

// ===== hw/rtl/tpad_regs.sv =====
// ----------------------------------------------------------------------------
// tpad_regs
// apb configuration registers: detect count, vote window and margins
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpad_regs import tpad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;
  logic [CFG_W-1:0] rd_val;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DETECT_COUNT: cfg_d.detect_count = pwdata[CFG_W-1:0];
        REG_VOTE_WINDOW:  cfg_d.vote_window  = pwdata[CFG_W-1:0];
        REG_FWD_MARGIN:   cfg_d.fwd_margin   = pwdata[CFG_W-1:0];
        REG_BWD_MARGIN:   cfg_d.bwd_margin   = pwdata[CFG_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DETECT_COUNT: rd_val = cfg_q.detect_count;
      REG_VOTE_WINDOW:  rd_val = cfg_q.vote_window;
      REG_FWD_MARGIN:   rd_val = cfg_q.fwd_margin;
      REG_BWD_MARGIN:   rd_val = cfg_q.bwd_margin;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(PDATA_W-CFG_W){1'b0}}, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_count <= DETECT_COUNT_RST;
      cfg_q.vote_window  <= VOTE_WINDOW_RST;
      cfg_q.fwd_margin   <= FWD_MARGIN_RST;
      cfg_q.bwd_margin   <= BWD_MARGIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/track_pulse_timer_analog_detector.sv =====
// ----------------------------------------------------------------------------
// track_pulse_timer_analog_detector
// pulse width timer on the track pin with analog track and direction detect
// ----------------------------------------------------------------------------
// One input item per microsecond tick carries the pin level, comparator output
// and the sample, clear and take strobes. Every item gives exactly one result
// item: the taken pulse width, analog mode, pwm-seen flag and direction.
// Both channels use valid/stall; an item moves when valid is high and stall
// low. The block takes one item every clock cycle while in_stall_o is low;
// each item waits in the input register until the result register is free,
// then moves into the result register, which offers it. The state update
// of an item sits in the single logic stage between the two registers, so the
// next tick sees it at once.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more; after that in_stall_o rises until the result moves.
// Reset clears the tick counter, held width, analog level, vote counters and
// direction, empties both registers and loads the register defaults (detect
// count 8, window 31, forward margin 13, backward margin 9). Registers are to
// be written over the apb port only while no item is in flight; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module track_pulse_timer_analog_detector import tpad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               pin_level_i,
  input  logic               comparator_out_i,
  input  logic               sample_strobe_i,
  input  logic               clear_analog_i,
  input  logic               take_width_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TICK_W-1:0]  pulse_width_o,
  output logic               analog_mode_o,
  output logic               pwm_seen_o,
  output logic [1:0]         direction_o
);

  `include "assert_macros.svh"

  cfg_t cfg;

  tpad_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic accept, advance, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // input register
  logic pin_q, comp_q, sample_q, clr_q, take_q;

  // state
  logic              last_pin_q;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [TICK_W-1:0] held_q, held_d;
  logic [CFG_W-1:0]  level_q, level_d;
  logic              pwm_q, pwm_d;
  logic [CFG_W-1:0]  scount_q, scount_d;
  logic [CFG_W-1:0]  right_q, right_d;
  logic [CFG_W-1:0]  left_q, left_d;
  dir_e              dir_q, dir_d;

  // result register
  logic [TICK_W-1:0] width_q, width_d;
  logic              analog_q, analog_d;
  logic              pwm_out_q;
  dir_e              dir_out_q, dir_out_d;

  logic              analog_pre;
  logic [CFG_W-1:0]  level_clr;
  logic [TICK_W-1:0] tick_e, held_e;
  logic [CFG_W-1:0]  right_inc, left_inc, scount_inc;

  always_comb begin
    level_clr  = clr_q ? '0 : level_q;
    pwm_d      = clr_q ? 1'b0 : pwm_q;
    analog_pre = level_clr >= cfg.detect_count;
    tick_e     = tick_q;
    held_e     = held_q;

    // edge
    if (pin_q != last_pin_q) begin
      if (analog_pre) begin
        pwm_d = 1'b1;
      end else if (pin_q) begin
        tick_e = '0;
        held_e = '0;
      end else begin
        held_e = tick_q;
      end
    end

    // count
    tick_d  = tick_e + TICK_W'(1);
    level_d = level_clr;
    if (tick_e[7:0] == BYTE_FULL && tick_e[15:8] == BYTE_PRE_FULL &&
        level_clr < cfg.detect_count) begin
      level_d = level_clr + CFG_W'(1);
    end

    // sample
    scount_inc = scount_q + CFG_W'(1);
    right_inc  = right_q + CFG_W'(1);
    left_inc   = left_q + CFG_W'(1);
    scount_d   = scount_q;
    right_d    = right_q;
    left_d     = left_q;
    dir_d      = dir_q;
    if (sample_q) begin
      scount_d = scount_inc;
      if (pin_q && comp_q) begin
        right_d = right_inc;
      end else begin
        left_d = left_inc;
      end
      if (scount_inc >= cfg.vote_window) begin
        if (right_d > left_d) begin
          if (CFG_W'(right_d - left_d) > cfg.fwd_margin) begin
            dir_d = DIR_FORWARD;
          end
        end else begin
          if (CFG_W'(left_d - right_d) > cfg.bwd_margin) begin
            dir_d = DIR_BACKWARD;
          end
        end
        scount_d = '0;
        right_d  = '0;
        left_d   = '0;
      end
    end

    // take
    width_d = take_q ? held_e : '0;
    held_d  = take_q ? '0 : held_e;

    analog_d  = level_d >= cfg.detect_count;
    dir_out_d = analog_d ? dir_d : DIR_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_pin_q  <= 1'b0;
      tick_q      <= '0;
      held_q      <= '0;
      level_q     <= '0;
      pwm_q       <= 1'b0;
      scount_q    <= '0;
      right_q     <= '0;
      left_q      <= '0;
      dir_q       <= DIR_NONE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        last_pin_q <= pin_q;
        tick_q     <= tick_d;
        held_q     <= held_d;
        level_q    <= level_d;
        pwm_q      <= pwm_d;
        scount_q   <= scount_d;
        right_q    <= right_d;
        left_q     <= left_d;
        dir_q      <= dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pin_q    <= pin_level_i;
      comp_q   <= comparator_out_i;
      sample_q <= sample_strobe_i;
      clr_q    <= clear_analog_i;
      take_q   <= take_width_i;
    end
    if (advance) begin
      width_q   <= width_d;
      analog_q  <= analog_d;
      pwm_out_q <= pwm_d;
      dir_out_q <= dir_out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_width_o = width_q;
  assign analog_mode_o = analog_q;
  assign pwm_seen_o    = pwm_out_q;
  assign direction_o   = dir_out_q;

  `TPAD_ASSERT(a_dir_only_analog, (out_valid_o && !analog_mode_o) |-> (direction_o == DIR_NONE), "direction without analog mode")
  `TPAD_ASSERT(a_stall_when_full, (in_valid_q && out_valid_q && out_stall_i) |-> in_stall_o, "input not stalled with both registers full")
  `TPAD_ASSERT_NEXT(a_take_clears, (advance && take_q), (held_q == '0), "held width not cleared by take")
  `TPAD_ASSERT_NEXT(a_rise_restart, (advance && pin_q && !last_pin_q && !analog_pre), (tick_q == TICK_W'(1)), "rising edge did not restart counter")

endmodule

// ===== verif/track_pulse_timer_analog_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_pulse_timer_analog_detector_test
// Feeds timer ticks through the valid/stall input and checks every result item
// field by field against a tick-accurate predictor kept in step with the
// registers. The run covers directed edge, vote and take cases, zero and full
// register settings, a long pulse taken after its falling edge, and random
// pulses under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module track_pulse_timer_analog_detector_test import tpad_pkg::*;;

  typedef struct packed {
    logic pin;
    logic comp;
    logic strobe;
    logic clr;
    logic take;
  } tick_t;

  typedef struct packed {
    logic [TICK_W-1:0] width;
    logic              analog;
    logic              pwm;
    dir_e              dir;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               pin_level_i = 1'b0;
  logic               comparator_out_i = 1'b0;
  logic               sample_strobe_i = 1'b0;
  logic               clear_analog_i = 1'b0;
  logic               take_width_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [TICK_W-1:0]  pulse_width_o;
  logic               analog_mode_o;
  logic               pwm_seen_o;
  logic [1:0]         direction_o;

  track_pulse_timer_analog_detector u_top (.*);

  always #6 clk_i = ~clk_i;

  // predictor state and register copy
  cfg_t              cur_cfg = {DETECT_COUNT_RST, VOTE_WINDOW_RST, FWD_MARGIN_RST, BWD_MARGIN_RST};
  logic              trk_last_pin = 1'b0;
  logic [TICK_W-1:0] trk_ticks = '0;
  logic [TICK_W-1:0] trk_width = '0;
  logic [CFG_W-1:0]  trk_level = '0;
  logic              trk_pwm = 1'b0;
  logic [CFG_W-1:0]  vote_samples = '0;
  logic [CFG_W-1:0]  vote_right = '0;
  logic [CFG_W-1:0]  vote_left = '0;
  dir_e              trk_dir = DIR_NONE;

  tick_t   pending_ticks[$];
  result_t due_results[$];

  int n_errors = 0;
  int n_ticks = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_analog = 0;
  int n_pwm = 0;
  int n_widths = 0;
  int n_fwd = 0;
  int n_bwd = 0;

  int gap_max = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_max = 0;
  int stall_run = 0;

  logic gen_pin = 1'b0;
  int mix_rise, mix_fall, mix_comp, mix_strobe, mix_clr, mix_take;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < 30) begin
      $display("mismatch %s: got %0h, want %0h (result %0d)", what, got, want, n_results);
    end
    n_errors++;
  endtask

  // clear, then edge, then count, then sample, then take
  function automatic result_t advance_tick(input tick_t t);
    result_t          r;
    logic [CFG_W-1:0] margin;
    logic             in_analog;
    r = '0;
    if (t.clr) begin
      trk_level = '0;
      trk_pwm = 1'b0;
    end
    if (t.pin != trk_last_pin) begin
      if (trk_level >= cur_cfg.detect_count) begin
        trk_pwm = 1'b1;
      end else if (t.pin) begin
        trk_ticks = '0;
        trk_width = '0;
      end else begin
        trk_width = trk_ticks;
      end
    end
    trk_last_pin = t.pin;
    trk_ticks = trk_ticks + 1'b1;
    if (trk_ticks[CFG_W-1:0] == '0 && trk_ticks[TICK_W-1:CFG_W] == BYTE_FULL &&
        trk_level < cur_cfg.detect_count) begin
      trk_level = trk_level + 1'b1;
    end
    if (t.strobe) begin
      vote_samples = vote_samples + 1'b1;
      if (t.pin && t.comp) begin
        vote_right = vote_right + 1'b1;
      end else begin
        vote_left = vote_left + 1'b1;
      end
      if (vote_samples >= cur_cfg.vote_window) begin
        if (vote_right > vote_left) begin
          margin = vote_right - vote_left;
          if (margin > cur_cfg.fwd_margin) trk_dir = DIR_FORWARD;
        end else begin
          margin = vote_left - vote_right;
          if (margin > cur_cfg.bwd_margin) trk_dir = DIR_BACKWARD;
        end
        vote_samples = '0;
        vote_right = '0;
        vote_left = '0;
      end
    end
    if (t.take) begin
      r.width = trk_width;
      trk_width = '0;
    end
    in_analog = trk_level >= cur_cfg.detect_count;
    r.analog = in_analog;
    r.pwm = trk_pwm;
    r.dir = in_analog ? trk_dir : DIR_NONE;
    return r;
  endfunction

  // tick driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(advance_tick({pin_level_i, comparator_out_i, sample_strobe_i,
                                            clear_analog_i, take_width_i}));
        n_ticks++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          {pin_level_i, comparator_out_i, sample_strobe_i, clear_analog_i, take_width_i}
            <= pending_ticks.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = $urandom_range(0, gap_max);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result item with none due", 0, 0);
        end else begin
          want = due_results.pop_front();
          n_results++;
          if (pulse_width_o !== want.width) report_mismatch("pulse_width", pulse_width_o, want.width);
          if (analog_mode_o !== want.analog) report_mismatch("analog_mode", analog_mode_o, want.analog);
          if (pwm_seen_o !== want.pwm) report_mismatch("pwm_seen", pwm_seen_o, want.pwm);
          if (direction_o !== want.dir) report_mismatch("direction", direction_o, want.dir);
          if (want.analog) n_analog++;
          if (want.pwm) n_pwm++;
          if (want.width != 0) n_widths++;
          if (want.dir == DIR_FORWARD) n_fwd++;
          if (want.dir == DIR_BACKWARD) n_bwd++;
        end
      end
      if (stall_run != 0) begin
        stall_run--;
      end else if (!out_stall_i && stall_max != 0 && $urandom_range(0, 1) == 1) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, stall_max - 1);
      end else begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(0, 23);
      end
    end
  end

  task automatic cfg_read_check(input reg_idx_e idx, input logic [CFG_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== want) report_mismatch("register readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DETECT_COUNT: cur_cfg.detect_count = val;
      REG_VOTE_WINDOW:  cur_cfg.vote_window = val;
      REG_FWD_MARGIN:   cur_cfg.fwd_margin = val;
      REG_BWD_MARGIN:   cur_cfg.bwd_margin = val;
    endcase
    n_writes++;
    cfg_read_check(idx, val);
  endtask

  task automatic apply_cfg(input logic [CFG_W-1:0] detect, input logic [CFG_W-1:0] window,
                           input logic [CFG_W-1:0] fwd, input logic [CFG_W-1:0] bwd);
    cfg_write(REG_DETECT_COUNT, detect);
    cfg_write(REG_VOTE_WINDOW, window);
    cfg_write(REG_FWD_MARGIN, fwd);
    cfg_write(REG_BWD_MARGIN, bwd);
  endtask

  function automatic tick_t mk(input logic pin, input logic comp, input logic strobe,
                               input logic clr, input logic take);
    gen_pin = pin;
    return {pin, comp, strobe, clr, take};
  endfunction

  function automatic logic pct(input int p);
    return $urandom_range(0, 99) < p;
  endfunction

  task automatic set_mix(input int rise, input int fall, input int comp, input int strobe,
                         input int clr, input int take);
    mix_rise = rise;
    mix_fall = fall;
    mix_comp = comp;
    mix_strobe = strobe;
    mix_clr = clr;
    mix_take = take;
  endtask

  task automatic set_pace(input int gmax, input int smax);
    gap_max = gmax;
    stall_max = smax;
  endtask

  // pulses of random length with random strobes
  task automatic queue_random(input int n);
    logic pin;
    for (int i = 0; i < n; i++) begin
      pin = gen_pin;
      if (pin ? pct(mix_fall) : pct(mix_rise)) pin = !pin;
      pending_ticks.push_back(mk(pin, pct(mix_comp), pct(mix_strobe), pct(mix_clr),
                                 pct(mix_take)));
    end
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid_i || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    #20_000_000;
    $display("FAIL track_pulse_timer_analog_detector");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_read_check(REG_DETECT_COUNT, DETECT_COUNT_RST);
    cfg_read_check(REG_VOTE_WINDOW, VOTE_WINDOW_RST);
    cfg_read_check(REG_FWD_MARGIN, FWD_MARGIN_RST);
    cfg_read_check(REG_BWD_MARGIN, BWD_MARGIN_RST);

    // pulse timing, take and clear at reset settings
    set_pace(3, 3);
    pending_ticks.push_back(mk(0, 0, 0, 0, 0));
    pending_ticks.push_back(mk(0, 0, 0, 0, 1));
    pending_ticks.push_back(mk(1, 0, 0, 0, 0));
    pending_ticks.push_back(mk(1, 1, 1, 0, 0));
    pending_ticks.push_back(mk(1, 0, 0, 0, 0));
    pending_ticks.push_back(mk(0, 0, 0, 0, 1));
    pending_ticks.push_back(mk(1, 0, 0, 0, 0));
    pending_ticks.push_back(mk(0, 1, 1, 0, 0));
    pending_ticks.push_back(mk(0, 0, 0, 0, 1));
    pending_ticks.push_back(mk(0, 0, 0, 0, 1));
    pending_ticks.push_back(mk(1, 1, 1, 1, 1));
    pending_ticks.push_back(mk(1, 1, 1, 1, 0));
    pending_ticks.push_back(mk(0, 0, 0, 0, 0));
    wait_drained();

    set_mix(20, 20, 50, 50, 3, 20);
    set_pace(6, 6);
    queue_random(250);
    wait_drained();

    // zero detect count and window: analog at once, vote closes every sample
    apply_cfg(0, 0, 0, 0);
    pending_ticks.push_back(mk(0, 0, 0, 0, 0));
    pending_ticks.push_back(mk(1, 0, 0, 0, 0));
    pending_ticks.push_back(mk(1, 1, 1, 0, 0));
    pending_ticks.push_back(mk(0, 0, 1, 0, 0));
    pending_ticks.push_back(mk(0, 1, 1, 1, 0));
    pending_ticks.push_back(mk(1, 1, 1, 0, 1));
    pending_ticks.push_back(mk(1, 1, 0, 1, 0));
    pending_ticks.push_back(mk(1, 0, 1, 0, 0));
    wait_drained();

    set_mix(25, 25, 50, 70, 5, 20);
    set_pace(0, 8);
    queue_random(200);
    wait_drained();

    apply_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    set_mix(10, 10, 50, 80, 3, 20);
    set_pace(8, 0);
    queue_random(150);
    wait_drained();

    // one long pulse, taken after its falling edge
    apply_cfg(8'hFF, 7, 2, 1);
    set_pace(1, 2);
    pending_ticks.push_back(mk(0, 0, 0, 0, 0));
    pending_ticks.push_back(mk(1, 0, 0, 0, 0));
    for (int i = 0; i < 60; i++) begin
      pending_ticks.push_back(mk(1, pct(50), pct(50), 0, 0));
    end
    pending_ticks.push_back(mk(0, 0, 0, 0, 0));
    pending_ticks.push_back(mk(0, 0, 0, 0, 1));
    wait_drained();

    // back to back ticks with no receiver stalls
    apply_cfg(1, 9, 3, 3);
    set_mix(30, 30, 50, 50, 0, 20);
    set_pace(0, 0);
    queue_random(70);
    wait_drained();

    for (int k = 0; k < 4; k++) begin
      apply_cfg((k % 2 == 0) ? 8'd1 : 8'($urandom_range(1, 255)), 8'($urandom_range(1, 40)),
                8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)));
      set_mix(50, 8, (k % 2 == 0) ? 90 : 10, 60, 2, 20);
      set_pace($urandom_range(0, 8), $urandom_range(0, 8));
      queue_random(150);
      wait_drained();
    end

    if (due_results.size() != 0) report_mismatch("results never seen", due_results.size(), 0);
    $display("covered %0d ticks across %0d register writes; %0d analog results, %0d pwm seen",
             n_ticks, n_writes, n_analog, n_pwm);
    $display("%0d pulse widths taken; %0d forward and %0d backward results",
             n_widths, n_fwd, n_bwd);
    if (n_errors == 0) begin
      $display("PASS track_pulse_timer_analog_detector");
    end else begin
      $display("FAIL track_pulse_timer_analog_detector");
    end
    $finish;
  end

endmodule
